### hw/rtl/best_fit_page_chunk_allocator_assert.svh
// Assertion macros used by the allocator top level.
`ifndef BEST_FIT_PAGE_CHUNK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PAGE_CHUNK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFPCA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFPCA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bfpca_pkg.sv
// Shared types and constants of the best-fit page chunk allocator.
`timescale 1ns / 1ps
package bfpca_pkg;

  localparam int PAGE_W = 44;
  localparam int CNT_W  = 20;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int WORD_W = PAGE_W + CNT_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_ALL = '1;

  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_SHORT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_en;
    logic apply;
    logic shift_en;
    logic emit;
  } bfpca_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_shift;
    logic rd_last;
  } bfpca_sts_t;

endpackage

### hw/rtl/bfpca_dp.sv
// Datapath: chunk table memory, free total, best-fit search and result registers.
`timescale 1ns / 1ps
module bfpca_dp import bfpca_pkg::*; #(
  parameter int MAX_CHUNKS = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfpca_cmd_t           cmd,
  output bfpca_sts_t           sts,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [PAGE_W-1:0]    in_page_number,
  input  logic [CNT_W-1:0]     in_page_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_wdata,
  output logic [STAT_W-1:0]    out_status,
  output logic [PAGE_W-1:0]    out_base_page,
  output logic [CNT_W-1:0]     out_free_total
);

  localparam int IDX_W = $clog2(MAX_CHUNKS);
  localparam int ENT_W = $clog2(MAX_CHUNKS + 1);
  localparam int SW    = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 1;
  localparam logic [IDX_W:0]   DEPTH     = (IDX_W + 1)'(MAX_CHUNKS);
  localparam logic [IDX_W-1:0] TOP_ADDR  = IDX_W'(MAX_CHUNKS - 1);
  localparam logic [ENT_W-1:0] ENT_FULL  = ENT_W'(MAX_CHUNKS);
  localparam logic [SW-1:0]    COUNT_MAX = SW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [SW-1:0]    TOTAL_SAT = SW'(CNT_ALL);

  // logical table index to memory address (ring starting at head)
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, ofs};
    if (s >= DEPTH) s = s - DEPTH;
    return s[IDX_W-1:0];
  endfunction

  logic [WORD_W-1:0] mem [MAX_CHUNKS];

  logic [KIND_W-1:0] kind_r;
  logic [PAGE_W-1:0] page_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PAGE_W-1:0] pool_base_r;
  logic [CNT_W-1:0]  pool_cnt_r;

  logic [ENT_W-1:0]      entries_r, entries_nxt;
  logic [COUNT_BITS-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic                  iss_active_r, iss_active_nxt;
  logic [IDX_W-1:0]      iss_idx_r, iss_idx_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic                  rdv_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [WORD_W-1:0]     rd_data_r;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]      best_size_r, best_size_nxt;
  logic [PAGE_W-1:0]     best_base_r, best_base_nxt;
  logic [STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [PAGE_W-1:0]     res_base_r, res_base_nxt;
  logic [STAT_W-1:0]     out_status_r;
  logic [PAGE_W-1:0]     out_base_r;
  logic [CNT_W-1:0]      out_total_r;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [WORD_W-1:0]     mem_wd;

  logic [SW-1:0]     cnt_ext, sum_ext, pool_ext, sum_plus, sum_minus;
  logic [IDX_W-1:0]  head_dec;
  logic [CNT_W-1:0]  rd_size;
  logic [PAGE_W-1:0] rd_base;
  logic              exact;
  logic              best_is_tail;

  assign cnt_ext   = SW'(cnt_r);
  assign sum_ext   = SW'(sum_r);
  assign pool_ext  = SW'(pool_cnt_r);
  assign sum_plus  = sum_ext + cnt_ext;
  assign sum_minus = sum_ext - cnt_ext;
  assign head_dec  = (head_r == '0) ? TOP_ADDR : head_r - 1'b1;
  assign rd_size   = rd_data_r[CNT_W-1:0];
  assign rd_base   = rd_data_r[WORD_W-1:CNT_W];
  assign exact     = (best_size_r == cnt_r);
  assign best_is_tail = ((ENT_W'(best_idx_r) + ENT_W'(1)) == entries_r);

  assign sts.need_scan  = (kind_r == KIND_ALLOC) && (cnt_r != '0) &&
                          !(cnt_ext > sum_ext) && (entries_r != '0);
  assign sts.need_shift = found_r && exact && !best_is_tail;
  assign sts.rd_last    = rdv_r && (rd_idx_r == last_r);

  always_comb begin
    entries_nxt    = entries_r;
    sum_nxt        = sum_r;
    head_nxt       = head_r;
    iss_active_nxt = iss_active_r;
    iss_idx_nxt    = iss_idx_r;
    last_nxt       = last_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_base_nxt  = best_base_r;
    res_status_nxt = res_status_r;
    res_base_nxt   = res_base_r;
    mem_we         = 1'b0;
    mem_wa         = head_r;
    mem_wd         = {page_r, cnt_r};

    // read issue runs on its own until the last index goes out
    if (iss_active_r) begin
      iss_idx_nxt = iss_idx_r + 1'b1;
      if (iss_idx_r == last_r) iss_active_nxt = 1'b0;
    end

    if (cmd.exec) begin
      res_base_nxt = '0;
      case (kind_r)
        KIND_INIT: begin
          entries_nxt = '0;
          sum_nxt     = '0;
          if ((pool_cnt_r == '0) || (pool_base_r == '0) || (pool_ext > COUNT_MAX)) begin
            res_status_nxt = STAT_BAD;
          end else begin
            mem_we         = 1'b1;
            mem_wa         = head_r;
            mem_wd         = {pool_base_r, pool_cnt_r};
            entries_nxt    = ENT_W'(1);
            sum_nxt        = COUNT_BITS'(pool_ext);
            res_status_nxt = STAT_OK;
          end
        end
        KIND_ALLOC: begin
          if (cnt_r == '0) begin
            res_status_nxt = STAT_BAD;
          end else if (cnt_ext > sum_ext) begin
            res_status_nxt = STAT_SHORT;
          end else if (entries_r == '0) begin
            res_status_nxt = STAT_NOFIT;
          end else begin
            iss_active_nxt = 1'b1;
            iss_idx_nxt    = '0;
            last_nxt       = IDX_W'(entries_r - 1'b1);
            found_nxt      = 1'b0;
          end
        end
        KIND_FREE: begin
          if ((page_r == '0) || (cnt_r == '0)) begin
            res_status_nxt = STAT_BAD;
          end else if ((entries_r == ENT_FULL) || (sum_plus > COUNT_MAX)) begin
            res_status_nxt = STAT_FULL;
          end else begin
            mem_we         = 1'b1;
            mem_wa         = head_dec;
            mem_wd         = {page_r, cnt_r};
            head_nxt       = head_dec;
            entries_nxt    = entries_r + 1'b1;
            sum_nxt        = COUNT_BITS'(sum_plus);
            res_status_nxt = STAT_OK;
          end
        end
        default: begin
          res_status_nxt = STAT_BAD;
        end
      endcase
    end

    // strict less-than keeps the earliest of equal sizes
    if (cmd.scan_en && rdv_r) begin
      if ((rd_size >= cnt_r) && (!found_r || (rd_size < best_size_r))) begin
        found_nxt     = 1'b1;
        best_idx_nxt  = rd_idx_r;
        best_size_nxt = rd_size;
        best_base_nxt = rd_base;
      end
    end

    if (cmd.apply) begin
      if (!found_r) begin
        res_status_nxt = STAT_NOFIT;
      end else begin
        res_status_nxt = STAT_OK;
        res_base_nxt   = best_base_r;
        sum_nxt        = COUNT_BITS'(sum_minus);
        if (exact) begin
          entries_nxt = entries_r - 1'b1;
          if (!best_is_tail) begin
            iss_active_nxt = 1'b1;
            iss_idx_nxt    = best_idx_r + 1'b1;
            last_nxt       = IDX_W'(entries_r - 1'b1);
          end
        end else begin
          mem_we = 1'b1;
          mem_wa = phys(head_r, best_idx_r);
          mem_wd = {best_base_r + PAGE_W'(cnt_r), best_size_r - cnt_r};
        end
      end
    end

    // close the gap: each entry behind the removed one moves down one place
    if (cmd.shift_en && rdv_r) begin
      mem_we = 1'b1;
      mem_wa = phys(head_r, rd_idx_r - 1'b1);
      mem_wd = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (iss_active_r) rd_data_r <= mem[phys(head_r, iss_idx_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r    <= '0;
      sum_r        <= '0;
      head_r       <= '0;
      iss_active_r <= 1'b0;
      rdv_r        <= 1'b0;
      found_r      <= 1'b0;
      pool_base_r  <= '0;
      pool_cnt_r   <= '0;
    end else begin
      entries_r    <= entries_nxt;
      sum_r        <= sum_nxt;
      head_r       <= head_nxt;
      iss_active_r <= iss_active_nxt;
      rdv_r        <= iss_active_r;
      found_r      <= found_nxt;
      if (cfg_we && (cfg_index == REG_POOL_BASE))  pool_base_r <= cfg_wdata;
      if (cfg_we && (cfg_index == REG_POOL_COUNT)) pool_cnt_r  <= cfg_wdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r    <= iss_idx_nxt;
    last_r       <= last_nxt;
    rd_idx_r     <= iss_idx_r;
    best_idx_r   <= best_idx_nxt;
    best_size_r  <= best_size_nxt;
    best_base_r  <= best_base_nxt;
    res_status_r <= res_status_nxt;
    res_base_r   <= res_base_nxt;
    if (cmd.load) begin
      kind_r <= in_kind;
      page_r <= in_page_number;
      cnt_r  <= in_page_count;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_base_r   <= res_base_r;
      out_total_r  <= (sum_ext > TOTAL_SAT) ? CNT_ALL : sum_ext[CNT_W-1:0];
    end
  end

  assign out_status     = out_status_r;
  assign out_base_page  = out_base_r;
  assign out_free_total = out_total_r;

endmodule

### hw/rtl/bfpca_ctrl.sv
// Controller: sequences decode, search, update and table compaction; owns the handshakes.
`timescale 1ns / 1ps
module bfpca_ctrl import bfpca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output bfpca_cmd_t cmd,
  input  bfpca_sts_t sts
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = sts.need_scan ? S_SCAN : S_EMIT;
      S_SCAN:   if (sts.rd_last) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = sts.need_shift ? S_SHIFT : S_EMIT;
      S_SHIFT:  if (sts.rd_last) state_nxt = S_EMIT;
      S_EMIT:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: cmd.exec     = 1'b1;
      S_SCAN:   cmd.scan_en  = 1'b1;
      S_APPLY:  cmd.apply    = 1'b1;
      S_SHIFT:  cmd.shift_en = 1'b1;
      S_EMIT: begin
        cmd.emit = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/best_fit_page_chunk_allocator.sv
// Top level of the best-fit page chunk allocator: controller, datapath and checks.
`timescale 1ns / 1ps
// The block keeps an ordered table of free page chunks (base page, page count)
// in a single-port-write, registered-read memory of MAX_CHUNKS words, kept as
// a ring so that a freed chunk goes in at the head by moving the head pointer.
// One word is worked on at a time. Init, free and every request that is turned
// down before the search go from decode straight to emit. An allocation that
// reaches the search scans all N held entries through the memory read port,
// one entry per cycle, whether or not a chunk fits; an exact fit that is not
// the last entry then closes the gap by moving the K entries behind it down
// one place. A finished result sits in the output register while the next
// word is taken in; the block only stalls when a second result is ready and
// the first has not been taken. Configuration (pool base at index 0, pool
// count at index 1) is to be written on the cfg port only while the block is
// idle; the block itself does not enforce this. There is no clearing pass
// after reset: table entries are only read below the held count, and reset
// clears that count and the free total. Status codes: 0 ok, 1 bad request,
// 2 not enough free, 3 no chunk fits, 4 table full or free total would
// overflow COUNT_BITS.
`include "best_fit_page_chunk_allocator_assert.svh"
module best_fit_page_chunk_allocator import bfpca_pkg::*; #(
  parameter int MAX_CHUNKS = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [PAGE_W-1:0]    in_page_number,
  input  logic [CNT_W-1:0]     in_page_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [PAGE_W-1:0]    out_base_page,
  output logic [CNT_W-1:0]     out_free_total,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_wdata
);

  // command and status between the sequencer and the datapath
  bfpca_cmd_t cmd;
  bfpca_sts_t sts;

  // sequencer: handshakes and the step order of each word
  bfpca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memory, search registers, free total and result register
  bfpca_dp #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_page_number (in_page_number),
    .in_page_count  (in_page_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_status     (out_status),
    .out_base_page  (out_base_page),
    .out_free_total (out_free_total)
  );

  // one word in flight: an accept closes the input until the word is done
  `BFPCA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word accepted while busy")
  // only a successful allocation hands out a base page
  `BFPCA_ASSERT_IMP(a_base_only_ok, out_valid && (out_status != STAT_OK), out_base_page == '0, "base page on a failed item")
  // a result never overwrites one that is still waiting
  `BFPCA_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid || out_ready, "result register overwritten")

endmodule
